[hdl/dtc_pkg.sv]
// Shared types and constants for the digital potentiometer calibrator.
`timescale 1ns / 1ps

package dtc_pkg;

	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_CAL    = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	localparam logic [7:0] POT_CMD    = 8'h11;
	localparam logic [7:0] FULL_SCALE = 8'hff;

	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// One queued command: the first frame's channel and setting, and whether
	// the closing frame (setting plus one, done) follows it.
	typedef struct packed {
		logic [2:0] sel;
		logic [7:0] setting;
		logic       final_f;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[hdl/digipot_target_calibrator_core.sv]
// Top level of the digital potentiometer driver with target calibration.
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_ready, op/channel/value) takes one item per
// cycle whenever the command queue has room. A set or calibrate item with a
// valid channel, or a sample item during a search, becomes one queued command;
// other items are dropped with no frame.
// Output channel (out_valid/out_ready) carries write frames: select, spi_word
// (0x11 then 255 minus setting), setting, done_res and last.
// The first frame of an item passes through the queue, then the output register.
// A sample that ends the search yields a second frame (setting plus one,
// done_res and last high) in the cycle after the first is taken.
// Throughput: one frame per cycle while out_ready is high, set by the single
// output register; an item that yields two frames occupies it for both frames.
// Stalls: while out_ready is low the frame holds and the four-entry queue
// fills; in_ready drops only when the queue is full.
// Reset: idle, no search in progress, setting 255, queue and output empty.
//
module digipot_target_calibrator_core import dtc_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  channel,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  select,
	output logic [15:0] spi_word,
	output logic [7:0]  setting,
	output logic        done_res,
	output logic        last
);

	// queue handshake between front and back
	logic      q_push;
	logic      q_pop;
	cmd_t      q_in;
	cmd_t      q_head;
	q_status_t q_status;

	// front: classify items, track the search, issue commands
	dtc_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.channel (channel),
		.value   (value),
		.q_status(q_status),
		.push    (q_push),
		.push_cmd(q_in)
	);

	// decoupling queue
	dtc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_in),
		.pop     (q_pop),
		.head    (q_head),
		.status  (q_status)
	);

	// back: expand commands into frames
	dtc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_status (q_status),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.select   (select),
		.spi_word (spi_word),
		.setting  (setting),
		.done_res (done_res),
		.last     (last)
	);

	// a finished search always closes its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last)
		else $error("done frame without last");

	// the closing frame follows its first frame without a gap
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last && done_res)
		else $error("closing frame missing");

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue overflow");

	// the back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue underflow");

endmodule

[hdl/dtc_front.sv]
// Front end: accepts items, keeps the calibration state, issues frame commands.
`timescale 1ns / 1ps

module dtc_front import dtc_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [2:0] channel,
	input  logic [7:0] value,
	input  q_status_t  q_status,
	output logic       push,
	output cmd_t       push_cmd
);

	logic       busy_q;
	logic [2:0] cal_channel_q;
	logic [7:0] target_q;
	logic [7:0] setting_q;

	logic       accept;
	logic       ch_ok;
	logic [7:0] step_down;
	logic       stop;

	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign ch_ok     = {1'b0, channel} < 4'(NUM_CHANNELS);
	assign step_down = setting_q - 8'd1;
	assign stop      = (value <= target_q) || (step_down == 8'd0);

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		unique case (op_t'(op))
			OP_SET: begin
				push     = accept && ch_ok;
				push_cmd = '{sel: channel, setting: value, final_f: 1'b0};
			end
			OP_CAL: begin
				push     = accept && ch_ok;
				push_cmd = '{sel: channel, setting: FULL_SCALE, final_f: 1'b0};
			end
			OP_SAMPLE: begin
				push     = accept && busy_q;
				push_cmd = '{sel: cal_channel_q, setting: step_down, final_f: stop};
			end
			default: begin
				push     = 1'b0;
				push_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			cal_channel_q <= '0;
			target_q      <= '0;
			setting_q     <= FULL_SCALE;
		end else if (accept) begin
			if (op_t'(op) == OP_CAL && ch_ok) begin
				busy_q        <= 1'b1;
				cal_channel_q <= channel;
				target_q      <= value;
				setting_q     <= FULL_SCALE;
			end else if (op_t'(op) == OP_SAMPLE && busy_q) begin
				// on stop the answer is the setting before the step
				if (stop) begin
					busy_q <= 1'b0;
				end else begin
					setting_q <= step_down;
				end
			end
		end
	end

endmodule

[hdl/dtc_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module dtc_queue import dtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == CNT_W'(QDEPTH);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/dtc_back.sv]
// Back end: expands queued commands into write frames in an output register.
`timescale 1ns / 1ps

module dtc_back import dtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  q_status_t   q_status,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  select,
	output logic [15:0] spi_word,
	output logic [7:0]  setting,
	output logic        done_res,
	output logic        last
);

	logic       out_valid_q;
	logic [2:0] sel_q;
	logic [7:0] setting_q;
	logic       done_q;
	logic       last_q;
	logic       second_q;
	logic [2:0] second_sel_q;
	logic [7:0] second_set_q;
	logic       load;

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !second_q && !q_status.empty;

	assign out_valid = out_valid_q;
	assign select    = sel_q;
	assign setting   = setting_q;
	assign spi_word  = {POT_CMD, FULL_SCALE - setting_q};
	assign done_res  = done_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else begin
				out_valid_q <= !q_status.empty;
				second_q    <= !q_status.empty && head.final_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				sel_q     <= second_sel_q;
				setting_q <= second_set_q;
				done_q    <= 1'b1;
				last_q    <= 1'b1;
			end else begin
				sel_q        <= head.sel;
				setting_q    <= head.setting;
				done_q       <= 1'b0;
				last_q       <= !head.final_f;
				second_sel_q <= head.sel;
				second_set_q <= head.setting + 8'd1;
			end
		end
	end

endmodule

[tb/tb_digipot_target_calibrator_core.sv]
// Self-checking testbench for the digital potentiometer target calibrator core.
`timescale 1ns / 1ps

module tb_digipot_target_calibrator_core;
	import dtc_pkg::*;

	localparam int NUM_CHANNELS = 8;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 55;
	localparam int TAIL_CYCLES  = 10;

	// One expected write frame.
	typedef struct {
		logic [2:0]  sel;
		logic [15:0] word;
		logic [7:0]  setting;
		logic        done;
		logic        last;
	} frame_t;

	// Frame predictor and checker. Keeps its own copy of the search state and
	// a queue of frames due from the items accepted so far.
	class pot_frame_board;
		frame_t     frames_due[$];
		bit         searching;
		logic [2:0] search_ch;
		logic [7:0] target;
		logic [7:0] wiper;
		int         errors;

		function new();
			searching = 1'b0;
			search_ch = '0;
			target    = '0;
			wiper     = FULL_SCALE;
			errors    = 0;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function void push_frame(logic [2:0] sel, logic [7:0] level, logic done, logic last);
			frame_t f;
			f.sel     = sel;
			f.word    = {POT_CMD, FULL_SCALE - level};
			f.setting = level;
			f.done    = done;
			f.last    = last;
			frames_due.push_back(f);
		endfunction

		// Work out the frames one accepted item causes and queue them.
		function void predict_frames(op_t kind, logic [2:0] ch, logic [7:0] val);
			case (kind)
				OP_SET: begin
					if (ch < NUM_CHANNELS)
						push_frame(ch, val, 1'b0, 1'b1);
				end
				OP_CAL: begin
					if (ch < NUM_CHANNELS) begin
						searching = 1'b1;
						search_ch = ch;
						target    = val;
						wiper     = FULL_SCALE;
						push_frame(ch, FULL_SCALE, 1'b0, 1'b1);
					end
				end
				OP_SAMPLE: begin
					if (searching) begin
						wiper = wiper - 8'd1;
						if (val <= target || wiper == 8'd0) begin
							// step-down frame first, then the answer one above it
							push_frame(search_ch, wiper, 1'b0, 1'b0);
							wiper = wiper + 8'd1;
							push_frame(search_ch, wiper, 1'b1, 1'b1);
							searching = 1'b0;
						end else begin
							push_frame(search_ch, wiper, 1'b0, 1'b1);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		task check_frame(logic [2:0] sel, logic [15:0] word, logic [7:0] level,
				logic done, logic last);
			frame_t f;
			if (frames_due.size() == 0) begin
				report($sformatf("frame with none due (select %0d setting %0d)", sel, level));
				return;
			end
			f = frames_due.pop_front();
			if (sel !== f.sel)
				report($sformatf("select %0d, want %0d", sel, f.sel));
			if (word !== f.word)
				report($sformatf("spi_word %h, want %h", word, f.word));
			if (level !== f.setting)
				report($sformatf("setting %0d, want %0d", level, f.setting));
			if (done !== f.done)
				report($sformatf("done_res %b, want %b", done, f.done));
			if (last !== f.last)
				report($sformatf("last %b, want %b", last, f.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = 2'd0;
	logic [2:0]  channel = 3'd0;
	logic [7:0]  value = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  select;
	logic [15:0] spi_word;
	logic [7:0]  setting;
	logic        done_res;
	logic        last;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;

	pot_frame_board frames = new();

	digipot_target_calibrator_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.channel(channel),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.select(select),
		.spi_word(spi_word),
		.setting(setting),
		.done_res(done_res),
		.last(last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Drop the receiver's ready at random, at the rate the current phase sets.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watch both channels at each edge. Check the outgoing frame before noting
	// the incoming item: a frame never stems from an item taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				frames.check_frame(select, spi_word, setting, done_res, last);
			if (in_valid && in_ready)
				frames.predict_frames(op_t'(op), channel, value);
		end
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one item and hold it until taken. Valid is left high on return, so
	// the caller either offers the next item at once or lowers valid.
	task automatic send_item(op_t kind, logic [2:0] ch, logic [7:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		channel  <= ch;
		value    <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every frame due has come out. Step one edge
	// first so the item taken at the last edge is already noted.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending() != 0)
			@(posedge clk);
	endtask

	// Calibration search with random content: samples above the target (any value
	// if the target is 255), now and then a direct set or a restart, and mostly a
	// closing sample at or below the target. Returns the number of items sent.
	task automatic run_search(output int sent);
		logic [2:0] ch;
		logic [7:0] tgt;
		int         steps;
		sent  = 0;
		ch    = 3'($urandom_range(7));
		tgt   = 8'($urandom_range(255));
		steps = $urandom_range(1, 12);
		send_item(OP_CAL, ch, tgt);
		sent++;
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(99) < 10) begin
				send_item(OP_SET, 3'($urandom_range(7)), 8'($urandom_range(255)));
				sent++;
			end
			if ($urandom_range(99) < 3) begin
				tgt = 8'($urandom_range(255));
				send_item(OP_CAL, ch, tgt);
				sent++;
			end
			if (tgt == FULL_SCALE)
				send_item(OP_SAMPLE, 3'($urandom_range(7)), 8'($urandom_range(255)));
			else
				send_item(OP_SAMPLE, 3'($urandom_range(7)),
					8'($urandom_range(tgt + 1, 255)));
			sent++;
		end
		// leave about one search in five unfinished
		if ($urandom_range(99) < 80) begin
			send_item(OP_SAMPLE, 3'($urandom_range(7)), 8'($urandom_range(tgt)));
			sent++;
		end
	endtask

	task automatic run_phase(int tx_pct, int rx_pct, int n_items);
		int count;
		int sent;
		int pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		count = 0;
		while (count < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// noise: any op, any fields; idle samples and the unused op drop out
				send_item(op_t'($urandom_range(3)), 3'($urandom_range(7)),
					8'($urandom_range(255)));
			end else if (pick < 18) begin
				send_item(OP_SET, 3'($urandom_range(7)), 8'($urandom_range(255)));
				count++;
			end else if (pick < 20) begin
				wait_drain();
			end else begin
				run_search(sent);
				count += sent;
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, sender and receiver both busy at the first mix.
		tx_idle_pct = 36;
		rx_idle_pct = 59;
		send_item(OP_SET, 3'd0, 8'h00);
		send_item(OP_SET, 3'd7, 8'hff);
		send_item(OP_SET, 3'd2, 8'ha5);
		send_item(OP_SET, 3'd5, 8'h5a);
		send_item(OP_SAMPLE, 3'd0, 8'h00);      // idle: no frame
		send_item(OP_UNUSED, 3'd3, 8'h77);      // unused op: no frame
		send_item(OP_CAL, 3'd5, 8'h80);
		send_item(OP_SAMPLE, 3'd2, 8'hff);
		send_item(OP_SET, 3'd1, 8'h3c);         // direct set mid-search
		send_item(OP_SAMPLE, 3'd0, 8'h81);
		send_item(OP_SAMPLE, 3'd0, 8'h80);      // at target: two frames
		send_item(OP_SAMPLE, 3'd4, 8'h10);      // after completion: ignored
		send_item(OP_CAL, 3'd7, 8'hff);
		send_item(OP_SAMPLE, 3'd0, 8'h00);      // below target on first step
		send_item(OP_CAL, 3'd0, 8'h00);
		send_item(OP_SAMPLE, 3'd0, 8'hff);
		send_item(OP_CAL, 3'd3, 8'h40);         // restart while busy
		send_item(OP_SAMPLE, 3'd0, 8'hc0);
		send_item(OP_SAMPLE, 3'd0, 8'h00);
		send_item(OP_CAL, 3'd6, 8'h00);
		send_item(OP_SAMPLE, 3'd7, 8'h00);      // equal to a zero target
		send_item(OP_UNUSED, 3'd0, 8'h00);
		wait_drain();

		run_phase(36, 59, PHASE_ITEMS);
		wait_drain();
		run_phase(59, 36, PHASE_ITEMS);
		wait_drain();

		// Walk one search all the way down until the setting reaches zero.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_item(OP_CAL, 3'($urandom_range(7)), 8'h00);
		for (int i = 0; i < 255; i++)
			send_item(OP_SAMPLE, 3'($urandom_range(7)), 8'($urandom_range(1, 255)));
		run_phase(0, 0, PHASE_ITEMS);

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (frames.errors == 0 && frames.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
